/* hdl/hsv_to_rgb_converter_assert.svh */
// assertion macros for the hsv to rgb converter
// used by the top level only, no other dependencies
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// same-cycle implication, antecedent may be a sequence
`define H2R_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define H2R_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/h2r_pkg.sv */
// shared types, constants and helpers for the hsv to rgb pipeline
// no dependencies
`default_nettype none

package h2r_pkg;

  // full-scale denominator of the q and t levels: 255 * 65536
  localparam logic [23:0] LEVEL_DEN = 24'hFF_0000;
  localparam logic [7:0]  FULL_LEVEL = 8'd255;
  localparam logic [16:0] FRAC_ONE   = 17'h1_0000;

  // hue sectors
  localparam logic [2:0] SEC_RED_YEL   = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN   = 3'd1;
  localparam logic [2:0] SEC_GRN_CYN   = 3'd2;
  localparam logic [2:0] SEC_CYN_BLU   = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG   = 3'd4;
  localparam logic [2:0] SEC_MAG_RED   = 3'd5;

  // after hue scaling
  typedef struct packed {
    logic [2:0]  sector;
    logic [15:0] frac;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic [15:0] p_prod;
  } h2r_prep_t;

  // levels before the final divide by 255
  typedef struct packed {
    logic [2:0]  sector;
    logic [7:0]  val;
    logic [15:0] p_prod;
    logic [15:0] q_prod;
    logic [15:0] t_prod;
  } h2r_level_t;

  // floor(m / 255) for m up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] m);
    logic [16:0] sum;
    sum = {1'b0, m} + {9'd0, m[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

endpackage

`default_nettype wire

/* hdl/h2r_prep.sv */
// first stage: hue times six, sector split and grey level product
// depends on h2r_pkg
`default_nettype none

module h2r_prep (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [15:0]       hue_i,
  input  logic [7:0]        saturation_i,
  input  logic [7:0]        brightness_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output h2r_pkg::h2r_prep_t out_o
);
  import h2r_pkg::*;

  logic        valid_q;
  h2r_prep_t   beat_q, beat_d;
  logic [18:0] x;
  logic [7:0]  sat_inv;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = beat_q;

  always_comb begin
    x              = {1'b0, hue_i, 2'b00} + {2'b00, hue_i, 1'b0};
    sat_inv        = FULL_LEVEL - saturation_i;
    beat_d.sector  = x[18:16];
    beat_d.frac    = x[15:0];
    beat_d.sat     = saturation_i;
    beat_d.val     = brightness_i;
    beat_d.p_prod  = brightness_i * sat_inv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      beat_q <= beat_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/h2r_level.sv */
// second and third stages: saturation products, then value products for q and t
// depends on h2r_pkg
`default_nettype none

module h2r_level (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  h2r_pkg::h2r_prep_t in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output h2r_pkg::h2r_level_t out_o
);
  import h2r_pkg::*;

  typedef struct packed {
    logic [2:0]  sector;
    logic [7:0]  val;
    logic [15:0] p_prod;
    logic [23:0] sf;
    logic [23:0] sg;
  } h2r_sat_t;

  logic        v2_q, v3_q;
  logic        rdy3;
  h2r_sat_t    s2_q, s2_d;
  h2r_level_t  s3_q, s3_d;
  logic [16:0] g;
  logic [24:0] sg_full;
  logic [23:0] aq, at;
  logic [31:0] nq, nt;

  assign rdy3        = !v3_q || out_ready_i;
  assign in_ready_o  = !v2_q || rdy3;
  assign out_valid_o = v3_q;
  assign out_o       = s3_q;

  // stage two: s*f and s*(1-f)
  always_comb begin
    g           = FRAC_ONE - {1'b0, in_i.frac};
    sg_full     = in_i.sat * g;
    s2_d.sector = in_i.sector;
    s2_d.val    = in_i.val;
    s2_d.p_prod = in_i.p_prod;
    s2_d.sf     = in_i.sat * in_i.frac;
    s2_d.sg     = sg_full[23:0];
  end

  // stage three: v*(den - s*f) and v*(den - s*(1-f)), keep floor of /65536
  always_comb begin
    aq          = LEVEL_DEN - s2_q.sf;
    at          = LEVEL_DEN - s2_q.sg;
    nq          = s2_q.val * aq;
    nt          = s2_q.val * at;
    s3_d.sector = s2_q.sector;
    s3_d.val    = s2_q.val;
    s3_d.p_prod = s2_q.p_prod;
    s3_d.q_prod = nq[31:16];
    s3_d.t_prod = nt[31:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        v2_q <= in_valid_i;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s2_q <= s2_d;
    end
    if (rdy3 && v2_q) begin
      s3_q <= s3_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/h2r_swap.sv */
// last stage: divide levels by 255 and route them to r, g and b by sector
// depends on h2r_pkg
`default_nettype none

module h2r_swap (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  h2r_pkg::h2r_level_t in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          red_o,
  output logic [7:0]          green_o,
  output logic [7:0]          blue_o
);
  import h2r_pkg::*;

  logic       valid_q;
  logic [7:0] red_q, green_q, blue_q;
  logic [7:0] red_d, green_d, blue_d;
  logic [7:0] p, q, t, v;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

  always_comb begin
    v = in_i.val;
    p = div255(in_i.p_prod);
    q = div255(in_i.q_prod);
    t = div255(in_i.t_prod);
    unique case (in_i.sector)
      SEC_RED_YEL: begin red_d = v; green_d = t; blue_d = p; end
      SEC_YEL_GRN: begin red_d = q; green_d = v; blue_d = p; end
      SEC_GRN_CYN: begin red_d = p; green_d = v; blue_d = t; end
      SEC_CYN_BLU: begin red_d = p; green_d = q; blue_d = v; end
      SEC_BLU_MAG: begin red_d = t; green_d = p; blue_d = v; end
      default:     begin red_d = v; green_d = p; blue_d = q; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/hsv_to_rgb_converter.sv */
// hsv to rgb converter top level, four register stages
// an accepted input beat passes the prep, the two level and the swap registers to the output
// throughput: one pixel per cycle while the output is not stalled, set by the four-stage pipeline with no loops
// reset clears only the stage valid bits, data registers keep whatever they hold
// depends on h2r_pkg, h2r_prep, h2r_level, h2r_swap and hsv_to_rgb_converter_assert.svh
`default_nettype none
`include "hsv_to_rgb_converter_assert.svh"

module hsv_to_rgb_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] hue_i,
  input  logic [7:0]  saturation_i,
  input  logic [7:0]  brightness_i,
  // result beats
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o
);
  import h2r_pkg::*;

  // handshake between stages: each stage holds its beat until the next can take it
  logic       prep_ready, prep_valid;
  logic       level_ready, level_valid;
  logic       swap_ready;
  h2r_prep_t  prep_beat;
  h2r_level_t level_beat;

  assign in_stall_o = !prep_ready;

  // stage one: sector, fraction and the grey product v*(255-s)
  h2r_prep u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (prep_ready),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .out_valid_o  (prep_valid),
    .out_ready_i  (level_ready),
    .out_o        (prep_beat)
  );

  // stages two and three: saturation products, then brightness products for q and t
  h2r_level u_level (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prep_valid),
    .in_ready_o  (level_ready),
    .in_i        (prep_beat),
    .out_valid_o (level_valid),
    .out_ready_i (swap_ready),
    .out_o       (level_beat)
  );

  // stage four: exact divide by 255 and the six-sector channel swap,
  // its registers are the output registers
  h2r_swap u_swap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (level_valid),
    .in_ready_o  (swap_ready),
    .in_i        (level_beat),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  // input only stalls once every stage holds a beat
  `H2R_ASSERT_IMPL(a_stall_only_full, clk_i, rst_ni, in_stall_o, prep_valid && level_valid && out_valid_o, "input stalled with a free stage")
  // a full pipeline behind a stalled output must push back
  `H2R_ASSERT_IMPL(a_full_pushes_back, clk_i, rst_ni, out_valid_o && out_stall_i && prep_valid && level_valid && !level_ready, in_stall_o, "full pipeline accepted a beat")
  // with the output free, an accepted beat passes the prep, both level and the swap registers to the output
  `H2R_ASSERT_NEXT(a_latency, clk_i, rst_ni, (in_valid_i && !in_stall_o && !out_stall_i) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i, out_valid_o, "result missing after pipeline latency")

endmodule

`default_nettype wire
